/* hdl/stbs_pkg.sv */
// shared types and constants of the sorted table binary search core
package stbs_pkg;

  // fixed field widths
  localparam int unsigned IndexW  = 12;
  localparam int unsigned CodeW   = 21;
  localparam int unsigned FamilyW = 8;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned DimW    = 16;
  localparam int unsigned CountW  = 13;
  localparam int unsigned KeyW    = CodeW + FamilyW + SizeW;
  localparam int unsigned GeomW   = 2 * DimW;

  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // item modes
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeLookup = 1'b1;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [GeomW-1:0] geom_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic               lookup;
    logic               wr_ok;
    logic [IndexW-1:0]  index;
    key_t               key;
    geom_t              geom;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } back_state_e;

endpackage

/* hdl/stbs_front.sv */
// front end: accepts items, classifies them and queues them for the back end
module stbs_front #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [stbs_pkg::IndexW-1:0] entry_index_i,
  input  logic [stbs_pkg::CodeW-1:0]  codepoint_i,
  input  logic [stbs_pkg::FamilyW-1:0] font_generic_i,
  input  logic [stbs_pkg::SizeW-1:0]  size_px_i,
  input  logic [stbs_pkg::DimW-1:0]   glyph_width_i,
  input  logic [stbs_pkg::DimW-1:0]   glyph_height_i,
  output logic                        q_valid_o,
  output stbs_pkg::cmd_t              q_cmd_o,
  input  logic                        q_pop_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW   = (CntW > stbs_pkg::IndexW) ? CntW : stbs_pkg::IndexW;

  stbs_pkg::cmd_t                     entry_q [stbs_pkg::QueueDepth];
  logic [stbs_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [stbs_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [stbs_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  stbs_pkg::cmd_t                     cmd_new;
  logic                               push, pop;

  // classify the incoming beat
  always_comb begin
    cmd_new.lookup = (mode_i == stbs_pkg::ModeLookup);
    cmd_new.wr_ok  = (IW'(entry_index_i) < IW'(TABLE_DEPTH));
    cmd_new.index  = entry_index_i;
    cmd_new.key    = {codepoint_i, font_generic_i, size_px_i};
    cmd_new.geom   = {glyph_width_i, glyph_height_i};
  end

  assign in_ready_o = (cnt_q != stbs_pkg::QueueCntW'(stbs_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = entry_q[rd_ptr_q];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == stbs_pkg::QueuePtrW'(stbs_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == stbs_pkg::QueuePtrW'(stbs_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* hdl/stbs_back.sv */
// back end: table memory, binary search sequencer and result register
module stbs_back #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count_i,
  input  logic                               q_valid_i,
  input  stbs_pkg::cmd_t                     q_cmd_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [stbs_pkg::DimW-1:0]          result_width_o,
  output logic [stbs_pkg::DimW-1:0]          result_height_o
);

  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW    = (CntW > stbs_pkg::IndexW) ? CntW : stbs_pkg::IndexW;
  localparam int unsigned EntW  = stbs_pkg::KeyW + stbs_pkg::GeomW;

  logic [EntW-1:0]             mem [TABLE_DEPTH];
  logic [EntW-1:0]             rdata_q;

  stbs_pkg::back_state_e       state_q, state_d;
  logic [CntW-1:0]             low_q, low_d, high_q, high_d, mid_q, mid_d;
  stbs_pkg::key_t              key_q;
  logic                        res_hit_q;
  stbs_pkg::geom_t             res_geom_q;
  logic                        out_valid_q;
  logic                        out_hit_q;
  stbs_pkg::geom_t             out_geom_q;

  logic                        pop, do_load, do_lookup, do_read, do_cmp, done_fire;
  logic [IW-1:0]               wr_index;
  logic [AddrW-1:0]            wr_addr;
  stbs_pkg::key_t              probe_key;
  logic                        probe_lt, probe_gt;

  assign wr_index  = IW'(q_cmd_i.index);
  assign wr_addr   = wr_index[AddrW-1:0];
  assign probe_key = rdata_q[EntW-1:stbs_pkg::GeomW];
  assign probe_lt  = probe_key < key_q;
  assign probe_gt  = probe_key > key_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stbs_pkg::S_IDLE: begin
        if (q_valid_i && q_cmd_i.lookup) begin
          state_d = (count_i == '0) ? stbs_pkg::S_DONE : stbs_pkg::S_READ;
        end
      end
      stbs_pkg::S_READ: state_d = stbs_pkg::S_CMP;
      stbs_pkg::S_CMP: begin
        if (!probe_lt && !probe_gt) begin
          state_d = stbs_pkg::S_DONE;
        end else if (low_d < high_d) begin
          state_d = stbs_pkg::S_READ;
        end else begin
          state_d = stbs_pkg::S_DONE;
        end
      end
      stbs_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = stbs_pkg::S_IDLE;
        end
      end
      default: state_d = stbs_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop       = 1'b0;
    do_load   = 1'b0;
    do_lookup = 1'b0;
    do_read   = 1'b0;
    do_cmp    = 1'b0;
    done_fire = 1'b0;
    case (state_q)
      stbs_pkg::S_IDLE: begin
        pop       = q_valid_i;
        do_load   = q_valid_i && !q_cmd_i.lookup && q_cmd_i.wr_ok;
        do_lookup = q_valid_i && q_cmd_i.lookup;
      end
      stbs_pkg::S_READ: do_read = 1'b1;
      stbs_pkg::S_CMP:  do_cmp  = 1'b1;
      stbs_pkg::S_DONE: done_fire = !out_valid_q || out_ready_i;
      default: pop = 1'b0;
    endcase
  end

  assign q_pop_o = pop;

  // search bounds and probe position
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    mid_d  = mid_q;
    if (do_lookup) begin
      low_d  = '0;
      high_d = count_i;
    end
    if (do_read) begin
      mid_d = low_q + ((high_q - low_q) >> 1);
    end
    if (do_cmp) begin
      if (probe_lt) begin
        low_d = mid_q + 1'b1;
      end else if (probe_gt) begin
        high_d = mid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::S_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      mid_q       <= '0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      high_q  <= high_d;
      mid_q   <= mid_d;
      if (do_lookup) begin
        res_hit_q <= 1'b0;
      end else if (do_cmp && !probe_lt && !probe_gt) begin
        res_hit_q <= 1'b1;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // lookup key, matched geometry and output beat
  always_ff @(posedge clk_i) begin
    if (do_lookup) begin
      key_q      <= q_cmd_i.key;
      res_geom_q <= '0;
    end else if (do_cmp && !probe_lt && !probe_gt) begin
      res_geom_q <= rdata_q[stbs_pkg::GeomW-1:0];
    end
    if (done_fire) begin
      out_hit_q  <= res_hit_q;
      out_geom_q <= res_geom_q;
    end
  end

  // table memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[wr_addr] <= {q_cmd_i.key, q_cmd_i.geom};
    end
    if (do_read) begin
      rdata_q <= mem[mid_d[AddrW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign result_width_o  = out_geom_q[stbs_pkg::GeomW-1:stbs_pkg::DimW];
  assign result_height_o = out_geom_q[stbs_pkg::DimW-1:0];

  // a probe is only issued inside a nonempty window
  a_read_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stbs_pkg::S_READ |-> low_q < high_q)
    else $error("probe issued with empty search window");

  // compare always follows a memory read
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stbs_pkg::S_CMP |-> $past(state_q) == stbs_pkg::S_READ)
    else $error("compare without preceding read");

  // a pending result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_hit_q)
      && $stable(out_geom_q))
    else $error("pending result changed");

  // a miss carries zero geometry
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_hit_q |-> out_geom_q == '0)
    else $error("miss with nonzero geometry");

endmodule

/* hdl/sorted_table_binary_search_core.sv */
// top level: entry count register, front end, command queue and search back end
// load: two-entry queue, written to the table when popped; one per cycle if no lookup is running
// lookup: P probes, each a read plus a compare, P <= ceil(log2(count+1))
// one lookup in search at a time; the next item is popped once its result is registered
// empty table: no probes, the result is a miss; results wait in an output register
// reset clears control state and entry_count; table contents are undefined until loaded
module sorted_table_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stbs_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [stbs_pkg::IndexW-1:0]  entry_index_i,
  input  logic [stbs_pkg::CodeW-1:0]   codepoint_i,
  input  logic [stbs_pkg::FamilyW-1:0] font_generic_i,
  input  logic [stbs_pkg::SizeW-1:0]   size_px_i,
  input  logic [stbs_pkg::DimW-1:0]    glyph_width_i,
  input  logic [stbs_pkg::DimW-1:0]    glyph_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [stbs_pkg::DimW-1:0]    result_width_o,
  output logic [stbs_pkg::DimW-1:0]    result_height_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW   = (CntW > stbs_pkg::CountW) ? CntW : stbs_pkg::CountW;

  logic [stbs_pkg::CountW-1:0] entry_count_q;
  logic [EW-1:0]               count_ext;
  logic [CntW-1:0]             count_clamped;
  logic                        q_valid, q_pop;
  stbs_pkg::cmd_t              q_cmd;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // clamp the count to the table depth
  always_comb begin
    count_ext = (EW'(entry_count_q) > EW'(TABLE_DEPTH)) ? EW'(TABLE_DEPTH)
                                                         : EW'(entry_count_q);
    count_clamped = count_ext[CntW-1:0];
  end

  stbs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .entry_index_i  (entry_index_i),
    .codepoint_i    (codepoint_i),
    .font_generic_i (font_generic_i),
    .size_px_i      (size_px_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  stbs_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .count_i         (count_clamped),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .result_width_o  (result_width_o),
    .result_height_o (result_height_o)
  );

endmodule
